>>> hw/rtl/bmc_pkg.sv
// Shared types and constants for the bracket match checker.
// Depends on nothing; imported by bracket_match_checker.
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

  localparam int UNIT_W   = 16;
  localparam int REPORT_W = 24;
  localparam int CHAR_W   = 7;
  localparam int KIND_W   = 3;
  localparam int OUT_DATA_W = 72;

  localparam logic [UNIT_W-1:0] CH_LPAREN    = 16'h0028;
  localparam logic [UNIT_W-1:0] CH_RPAREN    = 16'h0029;
  localparam logic [UNIT_W-1:0] CH_LSQUARE   = 16'h005B;
  localparam logic [UNIT_W-1:0] CH_RSQUARE   = 16'h005D;
  localparam logic [UNIT_W-1:0] CH_DOLLAR    = 16'h0024;
  localparam logic [UNIT_W-1:0] CH_LBRACE    = 16'h007B;
  localparam logic [UNIT_W-1:0] CH_RBRACE    = 16'h007D;
  localparam logic [UNIT_W-1:0] CH_SLASH     = 16'h002F;
  localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] CH_DQUOTE    = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_SQUOTE    = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_NEWLINE   = 16'h000A;

  localparam logic [CHAR_W-1:0] ASC_LPAREN  = 7'h28;
  localparam logic [CHAR_W-1:0] ASC_RPAREN  = 7'h29;
  localparam logic [CHAR_W-1:0] ASC_LSQUARE = 7'h5B;
  localparam logic [CHAR_W-1:0] ASC_RSQUARE = 7'h5D;

  localparam logic [KIND_W-1:0] KIND_SURPLUS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MISMATCH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNCLOSED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

  localparam logic [15:0] EXPR_DEPTH_MAX = 16'hFFFF;

  typedef struct packed {
    logic                square;
    logic [REPORT_W-1:0] pos;
    logic [REPORT_W-1:0] line;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/bracket_match_checker.sv
// Bracket match checker: skips strings, ${...} expressions and // comments,
// keeps an opener stack in a memory with one write port and one registered read port and reports pairing errors.
// Depends on bmc_pkg.
//
//   Channel  Direction  Words
//   in_      slave      one code unit per word, tlast on the final unit
//   out_     master     one report per word, tlast on the last report of a unit
//
// A unit that is not a bracket is taken in the idle state; a bracket also needs an
// execute step, as the top of the stack comes from the memory's registered read port.
// A mismatched closer then passes a recovery state that pops entries until a
// matching opener is popped or the stack is empty.
// After the final unit, a flush state reports each unclosed opener, then the end record.
// Reset is synchronous; the stack memory is not cleared.
// A stalled result port holds the sequencer in any step that has a report to send.
`timescale 1ns / 1ps
`default_nettype none

module bracket_match_checker
  import bmc_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [UNIT_W-1:0]     in_tdata,   // code_unit
  input  wire logic                  in_tlast,   // final_unit
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // report_kind, bracket_seen, bracket_expected, char_position, line_number
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast   // last_of_run
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RECOVER, ST_FLUSH} state_t;

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
    cnt_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [REPORT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+REPORT_W-1:0] wide;
    logic [COUNT_BITS+REPORT_W-1:0] lim;
    wide = {{REPORT_W{1'b0}}, v};
    lim  = {{COUNT_BITS{1'b0}}, {REPORT_W{1'b1}}};
    sat_out = (wide > lim) ? {REPORT_W{1'b1}} : wide[REPORT_W-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  quote_r, quote_nxt;
  logic                  expr_r, expr_nxt;
  logic [15:0]           depth_r, depth_nxt;
  logic                  comment_r, comment_nxt;
  logic                  dollar_r, dollar_nxt;
  logic                  slash_r, slash_nxt;
  logic [UNIT_W-1:0]     prev_r, prev_nxt;
  logic [COUNT_BITS-1:0] offset_r, offset_nxt;
  logic [COUNT_BITS-1:0] line_r, line_nxt;
  logic                  fin_r, fin_nxt;
  logic                  open_r, open_nxt;
  logic                  sq_r, sq_nxt;
  logic [REPORT_W-1:0]   pos_r, pos_nxt;
  logic [REPORT_W-1:0]   lnum_r, lnum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  entry_t                mem [STACK_DEPTH];
  entry_t                rd_q;
  entry_t                wd;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [AW-1:0]         ra;
  logic [CW-1:0]         cnt_dec;

  logic                  in_acc;
  logic                  slot_free;
  logic                  emit;
  logic [KIND_W-1:0]     e_kind;
  logic [CHAR_W-1:0]     e_seen;
  logic [CHAR_W-1:0]     e_exp;
  logic [REPORT_W-1:0]   e_pos;
  logic [REPORT_W-1:0]   e_line;
  logic                  e_last;
  logic [UNIT_W-1:0]     u;
  logic                  go;
  logic [CHAR_W-1:0]     closer_ch;
  logic [CHAR_W-1:0]     opener_ch;
  state_t                done_st;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign u          = in_tdata;
  assign closer_ch  = sq_r ? ASC_RSQUARE : ASC_RPAREN;
  assign opener_ch  = sq_r ? ASC_LSQUARE : ASC_LPAREN;
  assign done_st    = fin_r ? ST_FLUSH : ST_IDLE;
  assign cnt_dec    = cnt_nxt - CW'(1);
  assign ra         = cnt_dec[AW-1:0];
  assign wa         = cnt_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    quote_nxt   = quote_r;
    expr_nxt    = expr_r;
    depth_nxt   = depth_r;
    comment_nxt = comment_r;
    dollar_nxt  = dollar_r;
    slash_nxt   = slash_r;
    prev_nxt    = prev_r;
    offset_nxt  = offset_r;
    line_nxt    = line_r;
    fin_nxt     = fin_r;
    open_nxt    = open_r;
    sq_nxt      = sq_r;
    pos_nxt     = pos_r;
    lnum_nxt    = lnum_r;
    go          = 1'b0;
    we          = 1'b0;
    wd.square   = sq_r;
    wd.pos      = pos_r;
    wd.line     = lnum_r;
    emit        = 1'b0;
    e_kind      = KIND_SURPLUS;
    e_seen      = '0;
    e_exp       = '0;
    e_pos       = pos_r;
    e_line      = lnum_r;
    e_last      = !fin_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          offset_nxt = cnt_inc(offset_r);
          pos_nxt    = sat_out(offset_nxt);
          lnum_nxt   = sat_out(line_r);
          fin_nxt    = in_tlast;
          dollar_nxt = 1'b0;
          slash_nxt  = 1'b0;
          if (comment_r) begin
            if (u == CH_NEWLINE) begin
              comment_nxt = 1'b0;
            end
          end else if (dollar_r && u == CH_LBRACE) begin
            expr_nxt = 1'b1;
            if (depth_r != EXPR_DEPTH_MAX) begin
              depth_nxt = depth_r + 16'd1;
            end
          end else if (slash_r && u == CH_SLASH) begin
            comment_nxt = 1'b1;
          end else begin
            if (u == CH_DOLLAR) begin
              dollar_nxt = 1'b1;
            end
            if (expr_r) begin
              if (u == CH_LBRACE) begin
                if (depth_r != EXPR_DEPTH_MAX) begin
                  depth_nxt = depth_r + 16'd1;
                end
              end else if (u == CH_RBRACE) begin
                if (depth_r <= 16'd1) begin
                  expr_nxt  = 1'b0;
                  depth_nxt = '0;
                end else begin
                  depth_nxt = depth_r - 16'd1;
                end
              end
            end else if ((u == CH_DQUOTE || u == CH_SQUOTE) && prev_r != CH_BACKSLASH) begin
              quote_nxt = !quote_r;
            end else if (quote_r) begin
              quote_nxt = quote_r;
            end else if (u == CH_SLASH) begin
              slash_nxt = 1'b1;
            end else if (u == CH_LPAREN || u == CH_LSQUARE) begin
              go       = 1'b1;
              open_nxt = 1'b1;
              sq_nxt   = (u == CH_LSQUARE);
            end else if (u == CH_RPAREN || u == CH_RSQUARE) begin
              go       = 1'b1;
              open_nxt = 1'b0;
              sq_nxt   = (u == CH_RSQUARE);
            end
          end
          prev_nxt = u;
          if (u == CH_NEWLINE) begin
            line_nxt = cnt_inc(line_r);
          end
          if (go) begin
            state_nxt = ST_EXEC;
          end else if (in_tlast) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_EXEC: begin
        if (open_r) begin
          if (cnt_r == FULL) begin
            if (slot_free) begin
              emit      = 1'b1;
              e_kind    = KIND_OVERFLOW;
              e_seen    = opener_ch;
              state_nxt = done_st;
            end
          end else begin
            we        = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = done_st;
          end
        end else if (cnt_r == '0) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_kind    = KIND_SURPLUS;
            e_seen    = closer_ch;
            state_nxt = done_st;
          end
        end else if (rd_q.square != sq_r) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_kind    = KIND_MISMATCH;
            e_seen    = closer_ch;
            e_exp     = opener_ch;
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = ST_RECOVER;
          end
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = done_st;
        end
      end
      ST_RECOVER: begin
        if (cnt_r == '0) begin
          state_nxt = done_st;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (rd_q.square == sq_r) begin
            state_nxt = done_st;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_last = 1'b0;
          if (cnt_r != '0) begin
            e_kind  = KIND_UNCLOSED;
            e_seen  = rd_q.square ? ASC_LSQUARE : ASC_LPAREN;
            e_pos   = rd_q.pos;
            e_line  = rd_q.line;
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            e_kind      = KIND_END;
            e_pos       = sat_out(offset_r);
            e_line      = sat_out(line_r);
            e_last      = 1'b1;
            quote_nxt   = 1'b0;
            expr_nxt    = 1'b0;
            depth_nxt   = '0;
            comment_nxt = 1'b0;
            dollar_nxt  = 1'b0;
            slash_nxt   = 1'b0;
            prev_nxt    = '0;
            offset_nxt  = '0;
            line_nxt    = COUNT_BITS'(1);
            fin_nxt     = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(OUT_DATA_W - KIND_W - 2*CHAR_W - 2*REPORT_W){1'b0}},
                       e_line, e_pos, e_exp, e_seen, e_kind};
      out_last_nxt  = e_last;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
      out_data_nxt  = out_data_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && wa == ra) begin
      rd_q <= wd;
    end else begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      quote_r     <= 1'b0;
      expr_r      <= 1'b0;
      depth_r     <= '0;
      comment_r   <= 1'b0;
      dollar_r    <= 1'b0;
      slash_r     <= 1'b0;
      prev_r      <= '0;
      offset_r    <= '0;
      line_r      <= COUNT_BITS'(1);
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      quote_r     <= quote_nxt;
      expr_r      <= expr_nxt;
      depth_r     <= depth_nxt;
      comment_r   <= comment_nxt;
      dollar_r    <= dollar_nxt;
      slash_r     <= slash_nxt;
      prev_r      <= prev_nxt;
      offset_r    <= offset_nxt;
      line_r      <= line_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    open_r     <= open_nxt;
    sq_r       <= sq_nxt;
    pos_r      <= pos_nxt;
    lnum_r     <= lnum_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("stack count above depth");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[KIND_W-1:0] == KIND_END |-> out_last_r)
    else $error("end record without tlast");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> !in_tready)
    else $error("ready right after final unit");

  a_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RECOVER || state_r == ST_FLUSH) |=> cnt_r <= $past(cnt_r))
    else $error("stack grew during recovery or flush");
`endif

endmodule

`default_nettype wire

>>> dv/bracket_match_checker_test.sv
// Self-checking testbench for bracket_match_checker: streams texts one code unit per word
// and predicts every report with an in-bench copy of the bracket stack and skip modes.
// Depends on bmc_pkg and the bracket_match_checker RTL.
`timescale 1ns / 1ps

module bracket_match_checker_test;
  import bmc_pkg::*;

  localparam int STACK_SLOTS = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [REPORT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   seen;
    logic [CHAR_W-1:0]   wanted;
    logic [REPORT_W-1:0] pos;
    logic [REPORT_W-1:0] line_no;
    logic                last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [UNIT_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  bracket_match_checker #(
    .STACK_DEPTH(STACK_SLOTS),
    .COUNT_BITS(24)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int error_count = 0;
  int units_sent = 0;
  int texts_sent = 0;
  int reports_seen = 0;
  int idle_cycles = 0;
  int kind_tally [0:4] = '{default: 0};

  report_t expected_reports[$];
  logic [UNIT_W-1:0] text_units[$];

  entry_t open_stack [STACK_SLOTS];
  int open_depth;
  bit quote_on, expr_on, comment_on, dollar_wait, slash_wait;
  logic [15:0] expr_nest;
  logic [UNIT_W-1:0] prev_unit;
  logic [REPORT_W-1:0] unit_total, line_total;

  function automatic logic [REPORT_W-1:0] bump(logic [REPORT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 24'd1;
  endfunction

  function automatic void clear_scan_state();
    open_depth = 0;
    quote_on = 0;
    expr_on = 0;
    comment_on = 0;
    dollar_wait = 0;
    slash_wait = 0;
    expr_nest = '0;
    prev_unit = '0;
    unit_total = '0;
    line_total = 24'd1;
  endfunction

  function automatic void add_report(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] seen,
                                     logic [CHAR_W-1:0] wanted, logic [REPORT_W-1:0] pos,
                                     logic [REPORT_W-1:0] line_no);
    report_t r;
    r.kind = kind;
    r.seen = seen;
    r.wanted = wanted;
    r.pos = pos;
    r.line_no = line_no;
    r.last = 1'b0;
    expected_reports.push_back(r);
  endfunction

  function automatic void match_bracket(logic [UNIT_W-1:0] u, logic [REPORT_W-1:0] pos,
                                        logic [REPORT_W-1:0] line_no);
    logic want_square;
    logic [CHAR_W-1:0] want_char;
    if (u == CH_LPAREN || u == CH_LSQUARE) begin
      if (open_depth >= STACK_SLOTS) begin
        add_report(KIND_OVERFLOW, u[CHAR_W-1:0], '0, pos, line_no);
      end else begin
        open_stack[open_depth].square = (u == CH_LSQUARE);
        open_stack[open_depth].pos = pos;
        open_stack[open_depth].line = line_no;
        open_depth++;
      end
    end else if (u == CH_RPAREN || u == CH_RSQUARE) begin
      want_square = (u == CH_RSQUARE);
      want_char = want_square ? ASC_LSQUARE : ASC_LPAREN;
      if (open_depth == 0) begin
        add_report(KIND_SURPLUS, u[CHAR_W-1:0], '0, pos, line_no);
      end else if (open_stack[open_depth-1].square != want_square) begin
        add_report(KIND_MISMATCH, u[CHAR_W-1:0], want_char, pos, line_no);
        while (open_depth > 0 && open_stack[open_depth-1].square != want_square)
          open_depth--;
        if (open_depth > 0)
          open_depth--;
      end else begin
        open_depth--;
      end
    end
  endfunction

  // Advances the scanner by one code unit and queues the reports it causes.
  function automatic void scan_unit(logic [UNIT_W-1:0] u, logic fin);
    bit had_dollar, had_slash;
    int first_new;
    logic [REPORT_W-1:0] pos, line_no;
    report_t tail;
    had_dollar = dollar_wait;
    had_slash = slash_wait;
    first_new = expected_reports.size();
    unit_total = bump(unit_total);
    pos = unit_total;
    line_no = line_total;
    dollar_wait = 0;
    slash_wait = 0;
    if (comment_on) begin
      if (u == CH_NEWLINE)
        comment_on = 0;
    end else if (had_dollar && u == CH_LBRACE) begin
      expr_on = 1;
      if (expr_nest != EXPR_DEPTH_MAX)
        expr_nest++;
    end else if (had_slash && u == CH_SLASH) begin
      comment_on = 1;
    end else begin
      if (u == CH_DOLLAR)
        dollar_wait = 1;
      if (expr_on) begin
        if (u == CH_LBRACE) begin
          if (expr_nest != EXPR_DEPTH_MAX)
            expr_nest++;
        end else if (u == CH_RBRACE) begin
          if (expr_nest <= 16'd1) begin
            expr_on = 0;
            expr_nest = '0;
          end else begin
            expr_nest--;
          end
        end
      end else if ((u == CH_DQUOTE || u == CH_SQUOTE) && prev_unit != CH_BACKSLASH) begin
        quote_on = !quote_on;
      end else if (quote_on) begin
      end else if (u == CH_SLASH) begin
        slash_wait = 1;
      end else begin
        match_bracket(u, pos, line_no);
      end
    end
    prev_unit = u;
    if (u == CH_NEWLINE)
      line_total = bump(line_total);
    if (fin) begin
      while (open_depth > 0) begin
        open_depth--;
        add_report(KIND_UNCLOSED, open_stack[open_depth].square ? ASC_LSQUARE : ASC_LPAREN,
                   '0, open_stack[open_depth].pos, open_stack[open_depth].line);
      end
      add_report(KIND_END, '0, '0, unit_total, line_total);
      clear_scan_state();
    end
    if (expected_reports.size() > first_new) begin
      tail = expected_reports.pop_back();
      tail.last = 1'b1;
      expected_reports.push_back(tail);
    end
  endfunction

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= out_idle_pct);

  function automatic void check_field(string name, logic [REPORT_W-1:0] exp_v,
                                      logic [REPORT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  report_t got_report, due_report;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_report = {out_tdata[2:0], out_tdata[9:3], out_tdata[16:10], out_tdata[40:17],
                    out_tdata[64:41], out_tlast};
      reports_seen++;
      if (got_report.kind <= KIND_END)
        kind_tally[got_report.kind]++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual %h", $time, got_report);
        error_count++;
      end else begin
        due_report = expected_reports.pop_front();
        check_field("report_kind", REPORT_W'(due_report.kind), REPORT_W'(got_report.kind));
        check_field("bracket_seen", REPORT_W'(due_report.seen), REPORT_W'(got_report.seen));
        check_field("bracket_expected", REPORT_W'(due_report.wanted),
                    REPORT_W'(got_report.wanted));
        check_field("char_position", due_report.pos, got_report.pos);
        check_field("line_number", due_report.line_no, got_report.line_no);
        check_field("last_of_run", REPORT_W'(due_report.last), REPORT_W'(got_report.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= unit;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    scan_unit(unit, fin);
    units_sent++;
  endtask

  task automatic send_text(input bit noisy);
    for (int i = 0; i < text_units.size(); i++)
      send_unit(text_units[i],
                (i == text_units.size() - 1) || (noisy && $urandom_range(24) == 0));
    texts_sent++;
  endtask

  task automatic send_string(input string s);
    text_units.delete();
    for (int i = 0; i < s.len(); i++)
      text_units.push_back({8'h00, s[i]});
    send_text(0);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do
      @(posedge clk);
    while (expected_reports.size() != 0);
  endtask

  function automatic logic [UNIT_W-1:0] pick_bracket();
    case ($urandom_range(3))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LSQUARE;
      default: return CH_RSQUARE;
    endcase
  endfunction

  function automatic logic [UNIT_W-1:0] pick_plain();
    case ($urandom_range(5))
      0: return CH_NEWLINE;
      1: return 16'h0020;
      default: return 16'h0061 + 16'($urandom_range(25));
    endcase
  endfunction

  function automatic logic [UNIT_W-1:0] pick_noise();
    logic [UNIT_W-1:0] bracket_unit;
    case ($urandom_range(15))
      0, 1, 2, 3: return pick_bracket();
      4: return CH_DQUOTE;
      5: return CH_SQUOTE;
      6: return CH_BACKSLASH;
      7: return CH_DOLLAR;
      8: return CH_LBRACE;
      9: return CH_RBRACE;
      10: return CH_SLASH;
      11: return CH_NEWLINE;
      12: return pick_plain();
      13: return 16'($urandom_range(16'hFFFF));
      14: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: begin
        bracket_unit = pick_bracket();
        return {8'($urandom_range(1, 255)), bracket_unit[7:0]};
      end
    endcase
  endfunction

  // A quoted string, a ${...} expression or a // comment that may hold brackets inside.
  task automatic add_skipped_span();
    logic [UNIT_W-1:0] quote;
    int span_len;
    span_len = $urandom_range(0, 4);
    case ($urandom_range(2))
      0: begin
        quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        text_units.push_back(quote);
        repeat (span_len) text_units.push_back($urandom_range(1) ? pick_bracket() : 16'h0078);
        text_units.push_back(quote);
      end
      1: begin
        text_units.push_back(CH_DOLLAR);
        text_units.push_back(CH_LBRACE);
        repeat (span_len) text_units.push_back($urandom_range(1) ? pick_bracket() : 16'h0078);
        text_units.push_back(CH_RBRACE);
      end
      default: begin
        text_units.push_back(CH_SLASH);
        text_units.push_back(CH_SLASH);
        repeat (span_len) text_units.push_back($urandom_range(1) ? pick_bracket() : 16'h0078);
        text_units.push_back(CH_NEWLINE);
      end
    endcase
  endtask

  task automatic build_balanced_text();
    logic [UNIT_W-1:0] pending_openers[$];
    logic [UNIT_W-1:0] opener;
    int roll;
    text_units.delete();
    repeat ($urandom_range(4, 24)) begin
      roll = $urandom_range(99);
      if (roll < 30 && pending_openers.size() < 12) begin
        opener = $urandom_range(1) ? CH_LSQUARE : CH_LPAREN;
        pending_openers.push_back(opener);
        text_units.push_back(opener);
      end else if (roll < 55 && pending_openers.size() > 0) begin
        text_units.push_back(pending_openers.pop_back() == CH_LPAREN ? CH_RPAREN : CH_RSQUARE);
      end else if (roll < 65) begin
        add_skipped_span();
      end else begin
        text_units.push_back(pick_plain());
      end
    end
    if ($urandom_range(9) != 0) begin
      while (pending_openers.size() > 0)
        text_units.push_back(pending_openers.pop_back() == CH_LPAREN ? CH_RPAREN : CH_RSQUARE);
    end
  endtask

  task automatic build_noise_text();
    text_units.delete();
    repeat ($urandom_range(1, 20)) text_units.push_back(pick_noise());
  endtask

  task automatic build_deep_text(input int openers, input int closers);
    text_units.delete();
    repeat (openers) begin
      if ($urandom_range(5) == 0)
        text_units.push_back(pick_plain());
      text_units.push_back($urandom_range(1) ? CH_LSQUARE : CH_LPAREN);
    end
    repeat (closers) text_units.push_back($urandom_range(1) ? CH_RSQUARE : CH_RPAREN);
  endtask

  task automatic test_error_reports();
    send_string(")");
    send_string("[((]\n(");
  endtask

  task automatic test_quote_skipping();
    send_string("\"(\\\"\"]");
  endtask

  task automatic test_expr_skipping();
    send_string("${(})$");
  endtask

  task automatic test_comment_skipping();
    send_string("//(\n(/");
  endtask

  // A full stack plus one more opener on the final unit gives the longest flush.
  task automatic test_stack_limits();
    build_deep_text(STACK_SLOTS, 0);
    text_units.push_back($urandom_range(1) ? CH_LSQUARE : CH_LPAREN);
    send_text(0);
    build_deep_text($urandom_range(STACK_SLOTS + 1, STACK_SLOTS + 4), $urandom_range(1, 3));
    send_text(0);
  endtask

  task automatic test_random_texts(input int unit_budget);
    int start_units;
    int roll;
    start_units = units_sent;
    while (units_sent - start_units < unit_budget) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        build_balanced_text();
        send_text(0);
      end else if (roll < 93) begin
        build_noise_text();
        send_text(1);
      end else begin
        build_deep_text($urandom_range(28, 36), $urandom_range(0, 3));
        send_text(0);
      end
      if ($urandom_range(7) == 0)
        hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    clear_scan_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 31;
    out_idle_pct = 61;
    test_error_reports();
    test_quote_skipping();
    test_expr_skipping();
    test_comment_skipping();
    test_random_texts(60);

    in_idle_pct = 61;
    out_idle_pct = 31;
    test_stack_limits();
    test_random_texts(60);

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_texts(60);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d code units in %0d texts and checked %0d reports.",
             units_sent, texts_sent, reports_seen);
    $display("Report kinds: surplus %0d, mismatch %0d, unclosed %0d, overflow %0d, end %0d.",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4]);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
